// File: hdl/ilid_pkg.sv
// Package for the indexed list: sizes, codes and beat payload types.
`default_nettype none

package ilid_pkg;

  // Sizes of the slot store
  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Request modes
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_READOUT = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // Input beat
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] item_value;
    logic [6:0]         position;
  } req_t;

  // Output beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               last_of_run;
  } rsp_t;

  // Keep the low VALUE_BITS bits of a request value
  function automatic logic [VALUE_BITS-1:0] store_value(input logic [31:0] v);
    logic [VALUE_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < VALUE_BITS; b++) begin
      if (b < 32) begin
        r[b] = v[b % 32];
      end
    end
    return r;
  endfunction

  // Sign-extend a stored value and narrow it to the 32-bit result field
  function automatic logic [31:0] fit_value(input logic [VALUE_BITS-1:0] s);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 32; b++) begin
      if (b < VALUE_BITS) begin
        r[b] = s[b % VALUE_BITS];
      end else begin
        r[b] = s[VALUE_BITS-1];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ilid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ilid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data; hold it when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/indexed_list_insert_delete.sv
// Top level of the indexed list: request sequencer around the slot memories.
`default_nettype none

// Bounded positional singly linked list of up to CAPACITY entries kept in
// three one-port-read RAMs (values, links, free-slot stack). One request is
// taken at a time. An insert at position p > 0 reads p links and a delete at
// position p > 0 reads p+1 links, at one link-RAM read per cycle. A read-out
// gives one result beat per cycle after the registered RAM read, while the
// output does not stall. A new request is taken while the last result beat
// still waits on the output register. The free stack needs no clearing pass
// after reset: entries below the lowest stack depth yet reached read as their
// own index.
module indexed_list_insert_delete (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ilid_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ilid_pkg::rsp_t     out_data_o
);

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_ALLOC      = 10'b00_0000_0010,
    ST_WALK       = 10'b00_0000_0100,
    ST_INS_LINK   = 10'b00_0000_1000,
    ST_INS_PREV   = 10'b00_0001_0000,
    ST_DEL_HEAD   = 10'b00_0010_0000,
    ST_DEL_VIC    = 10'b00_0100_0000,
    ST_DEL_UNLINK = 10'b00_1000_0000,
    ST_READ       = 10'b01_0000_0000,
    ST_RESP       = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [ilid_pkg::SLOT_W-1:0]     head_q, head_d;
  logic [ilid_pkg::CNT_W-1:0]      len_q, len_d;
  logic [ilid_pkg::CNT_W-1:0]      fc_q, fc_d;
  logic [ilid_pkg::CNT_W-1:0]      min_fc_q, min_fc_d;
  logic [ilid_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            first_q, first_d;
  logic                            is_ins_q, is_ins_d;
  logic                            pos_zero_q, pos_zero_d;
  logic                            fresh_q, fresh_d;
  logic [31:0]                     value_q, value_d;
  logic [ilid_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [ilid_pkg::SLOT_W-1:0]     prev_q, prev_d;
  logic [ilid_pkg::SLOT_W-1:0]     victim_q, victim_d;
  logic [1:0]                      status_q, status_d;
  logic                            out_valid_q, out_valid_d;
  ilid_pkg::rsp_t                  out_data_q, out_data_d;

  // RAM ports
  logic                            link_we, link_re;
  logic [ilid_pkg::SLOT_W-1:0]     link_waddr, link_wdata, link_raddr, link_rdata;
  logic                            val_we, val_re;
  logic [ilid_pkg::SLOT_W-1:0]     val_waddr, val_raddr;
  logic [ilid_pkg::VALUE_BITS-1:0] val_wdata, val_rdata;
  logic                            stk_we, stk_re;
  logic [ilid_pkg::SLOT_W-1:0]     stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  logic                            out_free;
  logic [ilid_pkg::SLOT_W-1:0]     walk_cur;
  logic [ilid_pkg::CNT_W-1:0]      fc_m1;
  logic [ilid_pkg::SLOT_W-1:0]     alloc_slot;
  logic [7:0]                      pos_x, len_x;
  logic [6:0]                      pos_m1;

  ilid_ram #(.WIDTH(ilid_pkg::SLOT_W), .DEPTH(ilid_pkg::CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  ilid_ram #(.WIDTH(ilid_pkg::VALUE_BITS), .DEPTH(ilid_pkg::CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  ilid_ram #(.WIDTH(ilid_pkg::SLOT_W), .DEPTH(ilid_pkg::CAPACITY)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Output register can take a beat this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // Current walk slot: head on the first step, else the link just read
  assign walk_cur   = first_q ? head_q : link_rdata;
  assign fc_m1      = fc_q - 1'b1;
  assign alloc_slot = fresh_q ? ilid_pkg::SLOT_W'(fc_m1) : stk_rdata;
  assign pos_x      = {1'b0, in_data_i.position};
  assign len_x      = 8'(len_q);
  assign pos_m1     = in_data_i.position - 7'd1;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Sequence one request
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    len_d       = len_q;
    fc_d        = fc_q;
    min_fc_d    = min_fc_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    is_ins_d    = is_ins_q;
    pos_zero_d  = pos_zero_q;
    fresh_d     = fresh_q;
    value_d     = value_q;
    slot_d      = slot_q;
    prev_d      = prev_q;
    victim_d    = victim_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = head_q;
    link_re    = 1'b0;
    link_raddr = head_q;
    val_we     = 1'b0;
    val_waddr  = alloc_slot;
    val_wdata  = ilid_pkg::store_value(value_q);
    val_re     = 1'b0;
    val_raddr  = head_q;
    stk_we     = 1'b0;
    stk_waddr  = ilid_pkg::SLOT_W'(fc_q);
    stk_wdata  = head_q;
    stk_re     = 1'b0;
    stk_raddr  = ilid_pkg::SLOT_W'(fc_m1);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          value_d    = in_data_i.item_value;
          is_ins_d   = (in_data_i.mode == ilid_pkg::MODE_INSERT);
          pos_zero_d = (in_data_i.position == 7'd0);
          cnt_d      = ilid_pkg::CNT_W'(pos_m1);
          first_d    = 1'b1;
          state_d    = ST_RESP;
          case (in_data_i.mode)
            ilid_pkg::MODE_INSERT: begin
              if (pos_x > len_x) begin
                status_d = ilid_pkg::STAT_INVALID;
              end else if (fc_q == '0) begin
                status_d = ilid_pkg::STAT_FULL;
              end else begin
                // pop the free stack top
                stk_re  = 1'b1;
                fresh_d = (fc_m1 < min_fc_q);
                state_d = ST_ALLOC;
              end
            end
            ilid_pkg::MODE_DELETE: begin
              if (len_q == '0) begin
                status_d = ilid_pkg::STAT_EMPTY;
              end else if (pos_x >= len_x) begin
                status_d = ilid_pkg::STAT_INVALID;
              end else if (in_data_i.position == 7'd0) begin
                link_re = 1'b1;
                state_d = ST_DEL_HEAD;
              end else begin
                state_d = ST_WALK;
              end
            end
            ilid_pkg::MODE_READOUT: begin
              if (len_q == '0) begin
                status_d = ilid_pkg::STAT_EMPTY;
              end else begin
                link_re = 1'b1;
                val_re  = 1'b1;
                cnt_d   = len_q;
                state_d = ST_READ;
              end
            end
            default: begin
              status_d = ilid_pkg::STAT_INVALID;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        // store the value in the popped slot
        slot_d = alloc_slot;
        val_we = 1'b1;
        fc_d   = fc_m1;
        if (fresh_q) begin
          min_fc_d = fc_m1;
        end
        if (pos_zero_q) begin
          link_we    = 1'b1;
          link_waddr = alloc_slot;
          link_wdata = head_q;
          head_d     = alloc_slot;
          len_d      = len_q + 1'b1;
          status_d   = ilid_pkg::STAT_OK;
          state_d    = ST_RESP;
        end else begin
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        // advance one link per cycle; the last read fetches the link of prev
        link_re    = 1'b1;
        link_raddr = walk_cur;
        first_d    = 1'b0;
        if (cnt_q == '0) begin
          prev_d  = walk_cur;
          state_d = is_ins_q ? ST_INS_LINK : ST_DEL_VIC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end

      ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = link_rdata;
        state_d    = ST_INS_PREV;
      end

      ST_INS_PREV: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = slot_q;
        len_d      = len_q + 1'b1;
        status_d   = ilid_pkg::STAT_OK;
        state_d    = ST_RESP;
      end

      ST_DEL_HEAD: begin
        // unlink the head and push it on the free stack
        head_d    = link_rdata;
        stk_we    = 1'b1;
        stk_wdata = head_q;
        fc_d      = fc_q + 1'b1;
        len_d     = len_q - 1'b1;
        status_d  = ilid_pkg::STAT_OK;
        state_d   = ST_RESP;
      end

      ST_DEL_VIC: begin
        victim_d   = link_rdata;
        link_re    = 1'b1;
        link_raddr = link_rdata;
        state_d    = ST_DEL_UNLINK;
      end

      ST_DEL_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = link_rdata;
        stk_we     = 1'b1;
        stk_wdata  = victim_q;
        fc_d       = fc_q + 1'b1;
        len_d      = len_q - 1'b1;
        status_d   = ilid_pkg::STAT_OK;
        state_d    = ST_RESP;
      end

      ST_READ: begin
        // emit one entry per beat; hold the RAM data while stalled
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = ilid_pkg::STAT_OK;
          out_data_d.read_value  = ilid_pkg::fit_value(val_rdata);
          out_data_d.last_of_run = (cnt_q == ilid_pkg::CNT_W'(1));
          if (cnt_q == ilid_pkg::CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            link_re    = 1'b1;
            link_raddr = link_rdata;
            val_re     = 1'b1;
            val_raddr  = link_rdata;
            cnt_d      = cnt_q - 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.read_value  = '0;
          out_data_d.last_of_run = 1'b1;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      len_q       <= '0;
      fc_q        <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY);
      min_fc_q    <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      fc_q        <= fc_d;
      min_fc_q    <= min_fc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    first_q    <= first_d;
    is_ins_q   <= is_ins_d;
    pos_zero_q <= pos_zero_d;
    fresh_q    <= fresh_d;
    value_q    <= value_d;
    slot_q     <= slot_d;
    prev_q     <= prev_d;
    victim_q   <= victim_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  // Between requests every slot is either in the list or on the free stack
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |->
      (({1'b0, len_q} + {1'b0, fc_q}) == (ilid_pkg::CNT_W + 1)'(ilid_pkg::CAPACITY)))
    else $error("list length and free count do not add up to capacity");

  // The untouched-stack mark never lies above the stack depth
  a_min_fc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_fc_q <= fc_q)
    else $error("free stack mark above free count");

  // A read-out only runs on a non-empty list with entries left to emit
  a_read_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (cnt_q != '0 && cnt_q <= len_q))
    else $error("read-out count out of range");

  // An accepted request leaves the block out of idle in the cycle after
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE || out_valid_q))
    else $error("accepted request produced no work");
`endif

endmodule

`default_nettype wire
